>>> design/swdhe_pkg.sv
// swdhe_pkg: shared types and constants for the swd host transfer engine
// used by swdhe_cfg, swdhe_core and swd_host_transfer_engine_top; no dependencies
package swdhe_pkg;

	localparam int DataBits = 32;
	localparam int ReqLen   = 8;
	localparam int AckLen   = 3;
	localparam int DataLen  = 32 + 1;
	localparam int BackLen  = 1 + 32 + 1;
	localparam int TopBit   = 31;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_RAW   = 2'd2;

	localparam logic [2:0] ACK_OK    = 3'd1;
	localparam logic [2:0] ACK_WAIT  = 3'd2;
	localparam logic [2:0] ACK_FAULT = 3'd4;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_WAIT   = 3'd1;
	localparam logic [2:0] ST_FAULT  = 3'd2;
	localparam logic [2:0] ST_PROTO  = 3'd3;
	localparam logic [2:0] ST_PARITY = 3'd4;

	localparam logic [1:0] REG_TURNAROUND = 2'd0;
	localparam logic [1:0] REG_IDLE       = 2'd1;
	localparam logic [1:0] REG_DATA_WAIT  = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_REQ   = 4'd1,
		PH_TRN_A = 4'd2,
		PH_ACK   = 4'd3,
		PH_RD    = 4'd4,
		PH_TRN_B = 4'd5,
		PH_WR    = 4'd6,
		PH_IDLEC = 4'd7,
		PH_DUMR  = 4'd8,
		PH_DUMW  = 4'd9,
		PH_BACK  = 4'd10
	} phase_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  request;
		logic [31:0] write_data;
		logic        swdio_in;
		logic        raw_bit;
	} in_item_t;

	typedef struct packed {
		logic        swdio_out;
		logic        swdio_drive;
		logic        clock_pulse;
		logic        transfer_done;
		logic [2:0]  status;
		logic [2:0]  raw_ack;
		logic [31:0] read_data;
		logic        busy_res;
		logic        rejected;
	} out_item_t;

	typedef struct packed {
		logic [2:0] turnaround_cycles;
		logic [7:0] idle_cycles;
		logic       data_phase_on_wait;
	} cfg_t;

endpackage

>>> design/swdhe_cfg.sv
// swdhe_cfg: configuration register file of the swd host transfer engine
// depends on swdhe_pkg for cfg_t and register indexes
module swdhe_cfg import swdhe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turnaround_cycles  <= 3'd1;
			cfg_q.idle_cycles        <= 8'd0;
			cfg_q.data_phase_on_wait <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TURNAROUND: cfg_q.turnaround_cycles <= wr_data[2:0];
				REG_IDLE:       cfg_q.idle_cycles <= wr_data;
				REG_DATA_WAIT:  cfg_q.data_phase_on_wait <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/swdhe_core.sv
// swdhe_core: transfer sequencer, one item per call; phase, counter and shift state
// depends on swdhe_pkg for item, config and phase types
module swdhe_core import swdhe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t res
);

	phase_t      phase_q, phase_d, nx;
	logic [7:0]  cnt_q, cnt_d, cnt_inc, len;
	logic [31:0] sh_q, sh_d;
	logic        par_q, par_d;
	logic [3:0]  req_q, req_d;
	logic [2:0]  ack_q, ack_d;
	logic [2:0]  trn;
	logic        active, rd, dpw;

	assign active = (phase_q != PH_IDLE);
	assign rd     = req_q[1];
	assign dpw    = cfg.data_phase_on_wait;
	assign trn    = (cfg.turnaround_cycles == 3'd0) ? 3'd1 : cfg.turnaround_cycles;
	assign cnt_inc = cnt_q + 8'd1;

	always_comb begin
		case (phase_q)
			PH_REQ:                      len = 8'(ReqLen);
			PH_TRN_A, PH_TRN_B:          len = {5'd0, trn};
			PH_ACK:                      len = 8'(AckLen);
			PH_RD, PH_WR, PH_DUMR, PH_DUMW: len = 8'(DataLen);
			PH_IDLEC:                    len = cfg.idle_cycles;
			PH_BACK:                     len = 8'(BackLen);
			default:                     len = 8'd0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		sh_d    = sh_q;
		par_d   = par_q;
		req_d   = req_q;
		ack_d   = ack_q;
		nx      = PH_IDLE;
		res     = '0;
		res.swdio_out   = 1'b1;
		res.swdio_drive = 1'b1;
		case (item.func)
			FUNC_START: begin
				res.busy_res = 1'b1;
				if (active) begin
					res.rejected = 1'b1;
				end else begin
					req_d   = item.request;
					sh_d    = item.write_data;
					par_d   = 1'b0;
					ack_d   = 3'd0;
					cnt_d   = 8'd0;
					phase_d = PH_REQ;
				end
			end
			FUNC_RAW: begin
				if (active) begin
					res.rejected = 1'b1;
					res.busy_res = 1'b1;
				end else begin
					res.swdio_out   = item.raw_bit;
					res.clock_pulse = 1'b1;
				end
			end
			FUNC_TICK: begin
				if (active) begin
					res.clock_pulse = 1'b1;
					res.busy_res    = 1'b1;
					case (phase_q)
						PH_REQ: begin
							if (cnt_q == 8'd0)
								res.swdio_out = 1'b1;
							else if (cnt_q inside {[8'd1:8'd4]})
								res.swdio_out = req_q[cnt_q[1:0] - 2'd1];
							else if (cnt_q == 8'd5)
								res.swdio_out = ^req_q;
							else if (cnt_q == 8'd6)
								res.swdio_out = 1'b0;
							else
								res.swdio_out = 1'b1;
						end
						PH_ACK: begin
							res.swdio_out   = 1'b0;
							res.swdio_drive = 1'b0;
							if (cnt_q < 8'(AckLen))
								ack_d = ack_q | (3'(item.swdio_in) << cnt_q[1:0]);
						end
						PH_RD: begin
							res.swdio_out   = 1'b0;
							res.swdio_drive = 1'b0;
							if (cnt_q < 8'(DataBits)) begin
								sh_d  = {item.swdio_in, sh_q[TopBit:1]};
								par_d = par_q ^ item.swdio_in;
							end else if (cnt_q == 8'(DataBits)) begin
								par_d = par_q ^ item.swdio_in;
							end
						end
						PH_WR: begin
							if (cnt_q < 8'(DataBits)) begin
								res.swdio_out = sh_q[0];
								par_d = par_q ^ sh_q[0];
								sh_d  = {1'b0, sh_q[TopBit:1]};
							end else begin
								res.swdio_out = par_q;
							end
						end
						PH_IDLEC, PH_DUMW: begin
							res.swdio_out = 1'b0;
						end
						default: begin
							res.swdio_out   = 1'b0;
							res.swdio_drive = 1'b0;
						end
					endcase
					if (cnt_inc >= len) begin
						case (phase_q)
							PH_REQ:   nx = PH_TRN_A;
							PH_TRN_A: nx = PH_ACK;
							PH_ACK: begin
								if (ack_d == ACK_OK) begin
									par_d = 1'b0;
									if (rd) begin
										sh_d = '0;
										nx   = PH_RD;
									end else begin
										nx = PH_TRN_B;
									end
								end else if (ack_d == ACK_WAIT || ack_d == ACK_FAULT) begin
									nx = (rd && dpw) ? PH_DUMR : PH_TRN_B;
								end else begin
									nx = PH_BACK;
								end
							end
							PH_RD, PH_DUMR: nx = PH_TRN_B;
							PH_TRN_B: begin
								if (ack_d == ACK_OK)
									nx = rd ? PH_IDLEC : PH_WR;
								else
									nx = (!rd && dpw) ? PH_DUMW : PH_IDLE;
							end
							PH_WR:   nx = PH_IDLEC;
							default: nx = PH_IDLE;
						endcase
						if (nx == PH_IDLEC && cfg.idle_cycles == 8'd0)
							nx = PH_IDLE;
						phase_d = nx;
						cnt_d   = 8'd0;
						if (nx == PH_IDLE) begin
							res.transfer_done = 1'b1;
							res.raw_ack       = ack_d;
							if (ack_d == ACK_OK) begin
								res.status = (rd && par_d) ? ST_PARITY : ST_OK;
								if (rd)
									res.read_data = sh_d;
							end else if (ack_d == ACK_WAIT) begin
								res.status = ST_WAIT;
							end else if (ack_d == ACK_FAULT) begin
								res.status = ST_FAULT;
							end else begin
								res.status = ST_PROTO;
							end
						end
					end else begin
						cnt_d = cnt_inc;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 8'd0;
			sh_q    <= '0;
			par_q   <= 1'b0;
			req_q   <= 4'd0;
			ack_q   <= 3'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			sh_q    <= sh_d;
			par_q   <= par_d;
			req_q   <= req_d;
			ack_q   <= ack_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_start_enters_request: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !active && item.func == FUNC_START |=> phase_q == PH_REQ)
		else $error("start from idle did not enter request phase");
	a_done_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.transfer_done |=> phase_q == PH_IDLE)
		else $error("phase not idle after transfer end");
	a_request_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_REQ |-> cnt_q < 8'(ReqLen))
		else $error("request bit counter out of range");
	a_reject_no_clock: assert property (@(posedge clk) disable iff (!arst_n)
		res.rejected |-> !res.clock_pulse && active)
		else $error("rejected item produced a clock or came while idle");
`endif

endmodule

>>> design/swd_host_transfer_engine_top.sv
// an accepted item goes to the input register, and its result to the result register
// throughput: one item per cycle unless out_stall blocks; each tick item is one swclk period
// the sequencer state lives in swdhe_core and advances once per item
// reset: asynchronous active low; clears sequencer to idle, pipeline valids, and
// configuration to turnaround 1, idle 0, no data phase on wait
// depends on swdhe_pkg, swdhe_cfg and swdhe_core
module swd_host_transfer_engine_top import swdhe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic      in_valid_s1;
	in_item_t  in_item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	out_item_t res;
	cfg_t      cfg;
	logic      advance;

	assign advance   = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = in_valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	swdhe_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	swdhe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (in_item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_item_s1 <= in_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
